>>> rtl/core/vtdt_pkg.sv
// Package for the vertex triple dedup table.
// Holds default sizes, the sequencer state and command types and the probe control/status structs.
package vtdt_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int INDEX_BITS_DEF    = 24;
  localparam int VNUM_W            = 12;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_READ,
    S_CHECK
  } state_t;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic load;
    logic step;
  } probe_ctrl_t;

  typedef struct packed {
    logic occupied;
    logic hit;
  } probe_stat_t;

endpackage

>>> rtl/core/vtdt_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module vtdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/core/vtdt_probe.sv
// Probe unit: holds the search key, hashes it to a home slot, walks the slot
// pointer and compares each slot read against the key. Depends on vtdt_pkg.
module vtdt_probe #(
  parameter int INDEX_BITS = vtdt_pkg::INDEX_BITS_DEF,
  parameter int SLOT_BITS  = 13
) (
  input  logic                      clk,
  input  vtdt_pkg::probe_ctrl_t     ctrl,
  input  logic [INDEX_BITS-1:0]     position_index,
  input  logic [INDEX_BITS-1:0]     normal_index,
  input  logic [INDEX_BITS-1:0]     texcoord_index,
  input  logic                      rd_valid,
  input  logic [3*INDEX_BITS-1:0]   rd_key,
  output logic [3*INDEX_BITS-1:0]   key,
  output logic [SLOT_BITS-1:0]      slot,
  output vtdt_pkg::probe_stat_t     stat
);

  localparam int KeyW = 3 * INDEX_BITS;

  logic [KeyW-1:0]      key_in;
  logic [SLOT_BITS-1:0] home;

  assign key_in = {texcoord_index, normal_index, position_index};

  // XOR-fold the whole key down to a slot number
  always_comb begin
    home = '0;
    for (int i = 0; i < KeyW; i++) begin
      home[i % SLOT_BITS] = home[i % SLOT_BITS] ^ key_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key  <= key_in;
      slot <= home;
    end else if (ctrl.step) begin
      slot <= slot + 1'b1;
    end
  end

  assign stat.occupied = rd_valid;
  assign stat.hit      = rd_valid && (rd_key == key);

endmodule

>>> rtl/core/vertex_triple_dedup_table.sv
// Vertex triple dedup table: top level with sequencer, vertex counter and slot RAM.
// Depends on vtdt_pkg, vtdt_probe and vtdt_ram.
//
// Give a triple with start while busy is low; one result follows with done
// high for one cycle and cannot be stalled. Triples live in an open-addressed
// hash table of twice the entry count (rounded to a power of two) with linear
// probing, so a free slot always ends a search. A lookup loads the key in IDLE,
// reads the slot in READ and compares in CHECK; each extra slot probed repeats
// READ and CHECK on the single RAM port with registered read. After reset, and
// for every clear command, a sweep invalidates all 8192 slots (default size),
// one per cycle. busy stays high through it; a clear's result comes at its end.
module vertex_triple_dedup_table #(
  parameter int TABLE_ENTRIES = vtdt_pkg::TABLE_ENTRIES_DEF,
  parameter int INDEX_BITS    = vtdt_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command,
  input  logic [INDEX_BITS-1:0]         position_index,
  input  logic [INDEX_BITS-1:0]         normal_index,
  input  logic [INDEX_BITS-1:0]         texcoord_index,
  output logic                          done,
  output logic [vtdt_pkg::VNUM_W-1:0]   vertex_number,
  output logic                          is_new,
  output logic                          overflow
);

  localparam int VB        = $clog2(TABLE_ENTRIES);
  localparam int CW        = $clog2(TABLE_ENTRIES + 1);
  localparam int SLOT_BITS = $clog2(TABLE_ENTRIES) + 1;
  localparam int SLOTS     = 2 ** SLOT_BITS;
  localparam int KEY_W     = 3 * INDEX_BITS;
  localparam int WORD_W    = 1 + KEY_W + VB;

  vtdt_pkg::state_t      state, state_next;
  vtdt_pkg::probe_ctrl_t pctrl;
  vtdt_pkg::probe_stat_t pstat;

  logic [CW-1:0]        vcount;
  logic [SLOT_BITS-1:0] sweep_addr;
  logic                 clear_pend;
  logic [KEY_W-1:0]     key;
  logic [SLOT_BITS-1:0] slot;
  logic                 we;
  logic                 insert;
  logic                 full;
  logic [SLOT_BITS-1:0] ram_addr;
  logic [WORD_W-1:0]    wdata;
  logic [WORD_W-1:0]    rdata;
  logic [VB+vtdt_pkg::VNUM_W-1:0] rd_vnum_ext;
  logic [VB+vtdt_pkg::VNUM_W-1:0] cnt_vnum_ext;

  assign busy = (state != vtdt_pkg::S_IDLE);
  assign full = (vcount == CW'(TABLE_ENTRIES));

  vtdt_probe #(
    .INDEX_BITS (INDEX_BITS),
    .SLOT_BITS  (SLOT_BITS)
  ) u_probe (
    .clk            (clk),
    .ctrl           (pctrl),
    .position_index (position_index),
    .normal_index   (normal_index),
    .texcoord_index (texcoord_index),
    .rd_valid       (rdata[WORD_W-1]),
    .rd_key         (rdata[WORD_W-2 -: KEY_W]),
    .key            (key),
    .slot           (slot),
    .stat           (pstat)
  );

  assign ram_addr = (state == vtdt_pkg::S_SWEEP) ? sweep_addr : slot;
  assign wdata    = insert ? {1'b1, key, vcount[VB-1:0]} : '0;

  vtdt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (ram_addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign rd_vnum_ext  = {{vtdt_pkg::VNUM_W{1'b0}}, rdata[VB-1:0]};
  assign cnt_vnum_ext = {{vtdt_pkg::VNUM_W{1'b0}}, vcount[VB-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vtdt_pkg::S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pctrl      = '0;
    we         = 1'b0;
    insert     = 1'b0;
    case (state)
      vtdt_pkg::S_SWEEP: begin
        we = 1'b1;
        if (sweep_addr == '1) begin
          state_next = vtdt_pkg::S_IDLE;
        end
      end
      vtdt_pkg::S_IDLE: begin
        if (start) begin
          if (command == vtdt_pkg::CMD_CLEAR) begin
            state_next = vtdt_pkg::S_SWEEP;
          end else begin
            pctrl.load = 1'b1;
            state_next = vtdt_pkg::S_READ;
          end
        end
      end
      vtdt_pkg::S_READ: begin
        state_next = vtdt_pkg::S_CHECK;
      end
      vtdt_pkg::S_CHECK: begin
        if (!pstat.occupied) begin
          if (!full) begin
            we     = 1'b1;
            insert = 1'b1;
          end
          state_next = vtdt_pkg::S_IDLE;
        end else if (pstat.hit) begin
          state_next = vtdt_pkg::S_IDLE;
        end else begin
          // collision: advance to the next slot
          pctrl.step = 1'b1;
          state_next = vtdt_pkg::S_READ;
        end
      end
      default: begin
        state_next = vtdt_pkg::S_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      clear_pend <= 1'b0;
      vcount     <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == vtdt_pkg::S_SWEEP) begin
        sweep_addr <= sweep_addr + 1'b1;
        if (sweep_addr == '1 && clear_pend) begin
          clear_pend <= 1'b0;
          done       <= 1'b1;
        end
      end
      if (state == vtdt_pkg::S_IDLE && start && command == vtdt_pkg::CMD_CLEAR) begin
        clear_pend <= 1'b1;
        vcount     <= '0;
      end
      if (insert) begin
        vcount <= vcount + 1'b1;
      end
      if (state == vtdt_pkg::S_CHECK && (!pstat.occupied || pstat.hit)) begin
        done <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == vtdt_pkg::S_SWEEP) begin
      vertex_number <= '0;
      is_new        <= 1'b0;
      overflow      <= 1'b0;
    end else if (state == vtdt_pkg::S_CHECK) begin
      if (pstat.hit) begin
        vertex_number <= rd_vnum_ext[vtdt_pkg::VNUM_W-1:0];
        is_new        <= 1'b0;
        overflow      <= 1'b0;
      end else if (full) begin
        vertex_number <= '0;
        is_new        <= 1'b0;
        overflow      <= 1'b1;
      end else begin
        vertex_number <= cnt_vnum_ext[vtdt_pkg::VNUM_W-1:0];
        is_new        <= 1'b1;
        overflow      <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    vcount <= CW'(TABLE_ENTRIES))
    else $error("vertex counter above table size");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == vtdt_pkg::S_CHECK || $past(state) == vtdt_pkg::S_SWEEP))
    else $error("result strobe without finished search or sweep");

  a_new_ovf: assert property (@(posedge clk) disable iff (rst)
    done |-> !(is_new && overflow))
    else $error("result both new and overflow");

  a_new_count: assert property (@(posedge clk) disable iff (rst)
    (done && is_new) |-> (vcount == $past(vcount) + 1'b1))
    else $error("insert without counter advance");

  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    insert |-> (!rdata[WORD_W-1] && !full))
    else $error("insert over an occupied slot or into a full table");

endmodule
